[hw/rtl/pap_pkg.sv]
package pap_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_GET    = 2'd2;
    localparam logic [1:0] CMD_LOCATE = 2'd3;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load_match;
        logic scan;
    } cell_ctrl_t;

endpackage

[hw/rtl/positional_array_list_top.sv]
// Ordered list of up to CAPACITY byte entries held in a row of cells, one
// entry per cell. On insert and delete every cell from the addressed one
// upward shifts toward or away from its neighbor at once, and for get and
// delete the addressed cell drives the read value. Locate first latches a
// match bit in every cell, then shifts the match bits one cell per cycle
// toward the head of the row until the first hit or the last entry in use
// appears.
// A new request is taken while a finished result waits, as long as the
// output register empties in the same cycle. Entry contents after reset are
// undefined; only entries below the count are ever read.
module positional_array_list_top
    import pap_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] command, [8:2] position, [16:9] item_value, [23:17] zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] success, [8:1] read_value, [15:9] found_position,
    // [22:16] entry_count, [23] is_empty
    output logic [23:0] m_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int W  = (CW > 7) ? CW + 1 : 8;
    localparam logic [W-1:0] CAP_W = W'(CAPACITY);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic         state_reg,  state_next;
    logic [W-1:0] count_reg,  count_next;
    logic [W-1:0] scan_reg,   scan_next;
    logic         m_valid_reg, m_valid_next;
    logic [23:0]  m_data_reg, m_data_next;

    logic [1:0]   in_cmd;
    logic [W-1:0] in_pos;
    logic [7:0]   in_value;
    logic [W-1:0] sel_idx;
    logic         accept;
    logic         ins_ok, del_ok, get_ok;
    cell_ctrl_t   ctrl;
    logic [7:0]   read_any;

    logic [7:0] entry_w [CAPACITY];
    logic       match_w [CAPACITY];
    logic [7:0] read_w  [CAPACITY];

    assign in_cmd   = s_tdata[1:0];
    assign in_pos   = W'(s_tdata[8:2]);
    assign in_value = s_tdata[16:9];
    assign sel_idx  = in_pos - W'(1);

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign ins_ok = (in_pos != '0) && (in_pos <= count_reg + W'(1)) && (count_reg < CAP_W);
    assign del_ok = (in_pos != '0) && (in_pos <= count_reg);
    assign get_ok = del_ok;

    always_comb begin
        ctrl.shift_up   = accept && (in_cmd == CMD_INSERT) && ins_ok;
        ctrl.shift_down = accept && (in_cmd == CMD_DELETE) && del_ok;
        ctrl.load_match = accept && (in_cmd == CMD_LOCATE);
        ctrl.scan       = (state_reg == ST_SCAN);
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        pap_cell #(
            .W   (W),
            .IDX (i)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .sel_idx     (sel_idx),
            .count_val   (count_reg),
            .item_value  (in_value),
            .left_entry  ((i == 0) ? 8'h00 : entry_w[(i == 0) ? 0 : i - 1]),
            .right_entry ((i == CAPACITY - 1) ? 8'h00
                          : entry_w[(i == CAPACITY - 1) ? i : i + 1]),
            .right_match ((i == CAPACITY - 1) ? 1'b0
                          : match_w[(i == CAPACITY - 1) ? i : i + 1]),
            .entry       (entry_w[i]),
            .match       (match_w[i]),
            .read_out    (read_w[i])
        );
    end

    always_comb begin
        read_any = 8'h00;
        for (int i = 0; i < CAPACITY; i++) begin
            read_any = read_any | read_w[i];
        end
    end

    function automatic logic [23:0] pack_out(input logic ok, input logic [7:0] rv,
                                             input logic [W-1:0] fp,
                                             input logic [W-1:0] cnt);
        logic [23:0] d;
        d        = '0;
        d[0]     = ok;
        d[8:1]   = rv;
        d[15:9]  = fp[6:0];
        d[22:16] = cnt[6:0];
        d[23]    = (cnt == '0);
        return d;
    endfunction

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_INSERT: begin
                            if (ins_ok) begin
                                count_next = count_reg + W'(1);
                            end
                            m_valid_next = 1'b1;
                            m_data_next  = pack_out(ins_ok, 8'h00, '0,
                                                    ins_ok ? count_reg + W'(1) : count_reg);
                        end
                        CMD_DELETE: begin
                            if (del_ok) begin
                                count_next = count_reg - W'(1);
                            end
                            m_valid_next = 1'b1;
                            m_data_next  = pack_out(del_ok, del_ok ? read_any : 8'h00, '0,
                                                    del_ok ? count_reg - W'(1) : count_reg);
                        end
                        CMD_GET: begin
                            m_valid_next = 1'b1;
                            m_data_next  = pack_out(get_ok, get_ok ? read_any : 8'h00, '0,
                                                    count_reg);
                        end
                        default: begin
                            scan_next  = '0;
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (match_w[0]) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pack_out(1'b1, 8'h00, scan_reg + W'(1), count_reg);
                    state_next   = ST_IDLE;
                end else if (scan_reg + W'(1) >= count_reg) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pack_out(1'b1, 8'h00, '0, count_reg);
                    state_next   = ST_IDLE;
                end else begin
                    scan_next = scan_reg + W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        scan_reg   <= scan_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[hw/rtl/pap_cell.sv]
module pap_cell
    import pap_pkg::*;
#(
    parameter int W   = 8,
    parameter int IDX = 0
) (
    input  logic         aclk,
    input  cell_ctrl_t   ctrl,
    input  logic [W-1:0] sel_idx,
    input  logic [W-1:0] count_val,
    input  logic [7:0]   item_value,
    input  logic [7:0]   left_entry,
    input  logic [7:0]   right_entry,
    input  logic         right_match,
    output logic [7:0]   entry,
    output logic         match,
    output logic [7:0]   read_out
);

    localparam logic [W-1:0] MY_IDX = W'(IDX);

    logic [7:0] entry_reg;
    logic [7:0] entry_next;
    logic       match_reg;
    logic       match_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.shift_up) begin
            if (MY_IDX > sel_idx) begin
                entry_next = left_entry;
            end else if (MY_IDX == sel_idx) begin
                entry_next = item_value;
            end
        end else if (ctrl.shift_down) begin
            if (MY_IDX >= sel_idx) begin
                entry_next = right_entry;
            end
        end
    end

    always_comb begin
        match_next = match_reg;
        if (ctrl.load_match) begin
            match_next = (entry_reg == item_value) && (MY_IDX < count_val);
        end else if (ctrl.scan) begin
            match_next = right_match;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry    = entry_reg;
    assign match    = match_reg;
    assign read_out = (MY_IDX == sel_idx) ? entry_reg : 8'h00;

endmodule

[sim/positional_array_list_top_tb.sv]
`timescale 1ns / 1ps

module positional_array_list_top_tb;
    import pap_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int LONG_HOLD  = 400;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 200;

    typedef struct packed {
        logic [7:0] item_value;
        logic [6:0] position;
        logic [1:0] command;
    } list_req_t;

    typedef struct packed {
        logic       is_empty;
        logic [6:0] entry_count;
        logic [6:0] found_position;
        logic [7:0] read_value;
        logic       success;
    } list_rsp_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    list_req_t pending_reqs[$];
    list_rsp_t expected_rsps[$];

    logic [7:0] list_mem[CAPACITY];
    int         list_count;
    int         gen_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;

    logic req_taken     = 1'b0;
    logic long_hold_req = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_cnt      = 0;

    positional_array_list_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic list_rsp_t list_apply(list_req_t r);
        list_rsp_t rsp;
        int        p;
        rsp = '0;
        p = r.position;
        case (r.command)
            CMD_INSERT: begin
                if (p >= 1 && p <= list_count + 1 && list_count < CAPACITY) begin
                    for (int j = list_count; j > p - 1; j--)
                        list_mem[j] = list_mem[j - 1];
                    list_mem[p - 1] = r.item_value;
                    list_count++;
                    rsp.success = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (p >= 1 && p <= list_count) begin
                    rsp.read_value = list_mem[p - 1];
                    for (int j = p - 1; j + 1 < list_count; j++)
                        list_mem[j] = list_mem[j + 1];
                    list_count--;
                    rsp.success = 1'b1;
                end
            end
            CMD_GET: begin
                if (p >= 1 && p <= list_count) begin
                    rsp.read_value = list_mem[p - 1];
                    rsp.success    = 1'b1;
                end
            end
            default: begin
                for (int j = 0; j < list_count; j++)
                    if (rsp.found_position == 0 && list_mem[j] == r.item_value)
                        rsp.found_position = 7'(j + 1);
                rsp.success = 1'b1;
            end
        endcase
        rsp.entry_count = 7'(list_count);
        rsp.is_empty    = (list_count == 0);
        return rsp;
    endfunction

    task automatic push_req(input logic [1:0] cmd, input int pos, input logic [7:0] val);
        list_req_t r;
        r.command    = cmd;
        r.position   = 7'(pos);
        r.item_value = val;
        pending_reqs.push_back(r);
        if (cmd == CMD_INSERT && pos >= 1 && pos <= gen_count + 1 && gen_count < CAPACITY)
            gen_count++;
        else if (cmd == CMD_DELETE && pos >= 1 && pos <= gen_count)
            gen_count--;
    endtask

    task automatic gen_random(input int n, input int ins_pct, input int del_pct);
        int         roll;
        int         pos;
        logic [1:0] cmd;
        logic [7:0] val;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < ins_pct)
                cmd = CMD_INSERT;
            else if (roll < ins_pct + del_pct)
                cmd = CMD_DELETE;
            else if ($urandom_range(1))
                cmd = CMD_GET;
            else
                cmd = CMD_LOCATE;
            val = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
            roll = $urandom_range(99);
            if (roll < 85)
                pos = (cmd == CMD_INSERT) ? $urandom_range(gen_count + 1, 1)
                    : (gen_count == 0)    ? 1 : $urandom_range(gen_count, 1);
            else if (roll < 92)
                pos = $urandom_range(127);
            else if (roll < 95)
                pos = 0;
            else if (roll < 98)
                pos = gen_count + 1;
            else
                pos = gen_count + 2;
            push_req(cmd, pos, val);
        end
    endtask

    task automatic wait_sent();
        while (pending_reqs.size() != 0 || s_tvalid)
            @(posedge aclk);
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= {7'd0, pending_reqs.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold_req && !hold_done) begin
            m_tready <= 1'b0;
            if (hold_cnt == LONG_HOLD - 1)
                hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // predict on request, check on result
    always @(posedge aclk) begin
        list_rsp_t want;
        list_rsp_t got;
        req_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_rsps.push_back(list_apply(list_req_t'(s_tdata[16:0])));
        if (aresetn && m_tvalid && m_tready) begin
            got = list_rsp_t'(m_tdata);
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result %h", $realtime, m_tdata);
            end else begin
                want = expected_rsps.pop_front();
                if (got.success !== want.success || got.read_value !== want.read_value ||
                    got.found_position !== want.found_position ||
                    got.entry_count !== want.entry_count || got.is_empty !== want.is_empty) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: ok %b/%b rd %h/%h found %0d/%0d count %0d/%0d empty %b/%b",
                                 $realtime, want.success, got.success, want.read_value,
                                 got.read_value, want.found_position, got.found_position,
                                 want.entry_count, got.entry_count, want.is_empty,
                                 got.is_empty);
                end
            end
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("positional_array_list_top: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        list_count = 0;
        gen_count  = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        push_req(CMD_GET,    1,   8'h00);
        push_req(CMD_DELETE, 1,   8'h00);
        push_req(CMD_LOCATE, 0,   8'h00);
        push_req(CMD_INSERT, 0,   8'h11);
        push_req(CMD_INSERT, 2,   8'h22);
        push_req(CMD_INSERT, 127, 8'h33);
        push_req(CMD_INSERT, 1,   8'hFF);
        push_req(CMD_INSERT, 2,   8'h00);
        push_req(CMD_INSERT, 1,   8'h5A);
        push_req(CMD_INSERT, 2,   8'hA5);
        push_req(CMD_GET,    1,   8'h00);
        push_req(CMD_GET,    4,   8'h00);
        push_req(CMD_GET,    5,   8'h00);
        push_req(CMD_GET,    0,   8'h00);
        push_req(CMD_LOCATE, 127, 8'h00);
        push_req(CMD_LOCATE, 64,  8'h33);
        push_req(CMD_INSERT, 5,   8'hFF);
        push_req(CMD_LOCATE, 1,   8'hFF);
        push_req(CMD_DELETE, 6,   8'h00);
        push_req(CMD_DELETE, 0,   8'h00);
        push_req(CMD_DELETE, 5,   8'h00);
        push_req(CMD_DELETE, 1,   8'h00);
        push_req(CMD_DELETE, 2,   8'h00);
        push_req(CMD_DELETE, 127, 8'h00);

        // fill past capacity with no idling
        gen_random(300, 70, 10);
        wait_sent();

        // block the result side while requests keep coming
        long_hold_req = 1'b1;
        gen_random(120, 35, 35);
        while (!hold_done)
            @(posedge aclk);
        wait_sent();
        while (expected_rsps.size() != 0)
            @(posedge aclk);

        send_idle_pct = 88;
        gen_random(350, 30, 45);
        wait_sent();

        send_idle_pct  = 0;
        recv_stall_pct = 88;
        gen_random(350, 65, 15);
        wait_sent();

        send_idle_pct  = 25;
        recv_stall_pct = 25;
        gen_random(400, 35, 35);
        wait_sent();

        while (expected_rsps.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (expected_rsps.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("positional_array_list_top: match");
        else
            $display("positional_array_list_top: mismatch");
        $finish;
    end

endmodule
